@@ design/cpe_pkg.sv @@
// ----------------------------------------------------------------------------
// cpe_pkg
// Shared types and constants for the curve point evaluator: pipeline depth
// and the evaluation mode codes.
// ----------------------------------------------------------------------------
package cpe_pkg;

    // Register stages from input to output register, inclusive.
    localparam int NUM_STAGES = 8;

    typedef enum logic [1:0] {
        FUNC_LINEAR  = 2'd0,
        FUNC_QUAD    = 2'd1,
        FUNC_CUBIC   = 2'd2,
        FUNC_HERMITE = 2'd3
    } func_t;

endpackage

@@ design/cpe_if.sv @@
// ----------------------------------------------------------------------------
// cpe_in_if / cpe_out_if
// Valid/ready channels of the curve point evaluator: one carries a curve
// request (mode, four control points, parameter), the other a curve point.
// ----------------------------------------------------------------------------
interface cpe_in_if
    import cpe_pkg::*;
#(
    parameter int COORD_WIDTH     = 32,
    parameter int PARAM_FRAC_BITS = 16
);
    logic                          valid;
    logic                          ready;
    func_t                         func;
    logic signed [COORD_WIDTH-1:0] pt0_x;
    logic signed [COORD_WIDTH-1:0] pt0_y;
    logic signed [COORD_WIDTH-1:0] pt1_x;
    logic signed [COORD_WIDTH-1:0] pt1_y;
    logic signed [COORD_WIDTH-1:0] pt2_x;
    logic signed [COORD_WIDTH-1:0] pt2_y;
    logic signed [COORD_WIDTH-1:0] pt3_x;
    logic signed [COORD_WIDTH-1:0] pt3_y;
    logic [PARAM_FRAC_BITS:0]      curve_param;

    modport source (
        output valid, func, pt0_x, pt0_y, pt1_x, pt1_y,
               pt2_x, pt2_y, pt3_x, pt3_y, curve_param,
        input  ready
    );

    modport sink (
        input  valid, func, pt0_x, pt0_y, pt1_x, pt1_y,
               pt2_x, pt2_y, pt3_x, pt3_y, curve_param,
        output ready
    );
endinterface

interface cpe_out_if #(
    parameter int COORD_WIDTH = 32
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] out_x;
    logic signed [COORD_WIDTH-1:0] out_y;
    logic                          saturated;

    modport source (
        output valid, out_x, out_y, saturated,
        input  ready
    );

    modport sink (
        input  valid, out_x, out_y, saturated,
        output ready
    );
endinterface

@@ design/cpe_bezier_lane.sv @@
// ----------------------------------------------------------------------------
// cpe_bezier_lane
// One coordinate of the de Casteljau tree: three lerp levels, each split
// into a difference stage and a multiply-add stage.
// ----------------------------------------------------------------------------
module cpe_bezier_lane
    import cpe_pkg::*;
#(
    parameter int COORD_WIDTH     = 32,
    parameter int PARAM_FRAC_BITS = 16
)
(
    input  logic                          clk,
    input  logic [NUM_STAGES:1]           en,
    input  logic signed [COORD_WIDTH-1:0] p0,
    input  logic signed [COORD_WIDTH-1:0] p1,
    input  logic signed [COORD_WIDTH-1:0] p2,
    input  logic signed [COORD_WIDTH-1:0] p3,
    input  logic [PARAM_FRAC_BITS:0]      t_s1,
    input  logic [PARAM_FRAC_BITS:0]      t_s3,
    input  logic [PARAM_FRAC_BITS:0]      t_s5,
    output logic signed [COORD_WIDTH-1:0] lin,
    output logic signed [COORD_WIDTH-1:0] quad,
    output logic signed [COORD_WIDTH-1:0] cubic
);

    localparam int CW = COORD_WIDTH;
    localparam int F  = PARAM_FRAC_BITS;
    localparam int DW = CW + 1;
    localparam int PW = DW + F + 2;

    // a + floor(d * t / 2^F); for t up to one the result stays between a and a + d
    function automatic logic signed [CW-1:0] lerp_step(
        input logic signed [CW-1:0] a,
        input logic signed [DW-1:0] d,
        input logic [F:0]           t
    );
        logic signed [PW-1:0] prod;
        logic signed [PW-1:0] acc;
        prod = PW'(d) * PW'($signed({1'b0, t}));
        acc  = PW'(a) + (prod >>> F);
        return acc[CW-1:0];
    endfunction

    logic signed [CW-1:0] a0_reg, a1_reg, a2_reg;
    logic signed [DW-1:0] d0_reg, d1_reg, d2_reg;
    logic signed [CW-1:0] m0_reg, m1_reg, m2_reg;
    logic signed [DW-1:0] e0_reg, e1_reg;
    logic signed [CW-1:0] m0_s3_reg, m1_s3_reg;
    logic signed [CW-1:0] n0_reg, n1_reg;
    logic signed [DW-1:0] f_reg;
    logic signed [CW-1:0] n0_s5_reg;
    logic signed [CW-1:0] lin_s4_reg, lin_s5_reg, lin_s6_reg, lin_reg;
    logic signed [CW-1:0] quad_s6_reg, quad_reg;
    logic signed [CW-1:0] cubic_s6_reg, cubic_reg;

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            a0_reg <= p0;
            a1_reg <= p1;
            a2_reg <= p2;
            d0_reg <= DW'(p1) - DW'(p0);
            d1_reg <= DW'(p2) - DW'(p1);
            d2_reg <= DW'(p3) - DW'(p2);
        end
        if (en[2])
        begin
            m0_reg <= lerp_step(a0_reg, d0_reg, t_s1);
            m1_reg <= lerp_step(a1_reg, d1_reg, t_s1);
            m2_reg <= lerp_step(a2_reg, d2_reg, t_s1);
        end
        if (en[3])
        begin
            e0_reg    <= DW'(m1_reg) - DW'(m0_reg);
            e1_reg    <= DW'(m2_reg) - DW'(m1_reg);
            m0_s3_reg <= m0_reg;
            m1_s3_reg <= m1_reg;
        end
        if (en[4])
        begin
            n0_reg     <= lerp_step(m0_s3_reg, e0_reg, t_s3);
            n1_reg     <= lerp_step(m1_s3_reg, e1_reg, t_s3);
            lin_s4_reg <= m0_s3_reg;
        end
        if (en[5])
        begin
            f_reg      <= DW'(n1_reg) - DW'(n0_reg);
            n0_s5_reg  <= n0_reg;
            lin_s5_reg <= lin_s4_reg;
        end
        if (en[6])
        begin
            cubic_s6_reg <= lerp_step(n0_s5_reg, f_reg, t_s5);
            quad_s6_reg  <= n0_s5_reg;
            lin_s6_reg   <= lin_s5_reg;
        end
        if (en[7])
        begin
            cubic_reg <= cubic_s6_reg;
            quad_reg  <= quad_s6_reg;
            lin_reg   <= lin_s6_reg;
        end
    end

    assign lin   = lin_reg;
    assign quad  = quad_reg;
    assign cubic = cubic_reg;

endmodule

@@ design/cpe_hermite_weights.sv @@
// ----------------------------------------------------------------------------
// cpe_hermite_weights
// Hermite basis weights from t: t^2 and t^3 truncated to F fraction bits,
// then the four cubic basis polynomials.
// ----------------------------------------------------------------------------
module cpe_hermite_weights
    import cpe_pkg::*;
#(
    parameter int PARAM_FRAC_BITS = 16
)
(
    input  logic                              clk,
    input  logic [NUM_STAGES:1]               en,
    input  logic [PARAM_FRAC_BITS:0]          t_s1,
    input  logic [PARAM_FRAC_BITS:0]          t_s2,
    input  logic [PARAM_FRAC_BITS:0]          t_s3,
    output logic signed [PARAM_FRAC_BITS+3:0] h00,
    output logic signed [PARAM_FRAC_BITS+3:0] h01,
    output logic signed [PARAM_FRAC_BITS+3:0] h10,
    output logic signed [PARAM_FRAC_BITS+3:0] h11
);

    localparam int F  = PARAM_FRAC_BITS;
    localparam int TT = 2 * F + 2;
    localparam int HW = F + 4;
    localparam logic signed [HW-1:0] H_ONE = HW'(1) << F;

    logic [TT-1:0]        tsq_prod;
    logic [TT-1:0]        tcub_prod;
    logic [F:0]           tsq_reg;
    logic [F:0]           tsq_s3_reg;
    logic [F:0]           tcub_reg;
    logic signed [HW-1:0] tc, ts, tv, ts3;
    logic signed [HW-1:0] h00_next, h01_next, h10_next, h11_next;
    logic signed [HW-1:0] h00_reg, h01_reg, h10_reg, h11_reg;

    assign tsq_prod  = TT'(t_s1) * TT'(t_s1);
    assign tcub_prod = TT'(tsq_reg) * TT'(t_s2);

    always_comb
    begin
        tc       = HW'(tcub_reg);
        ts       = HW'(tsq_s3_reg);
        tv       = HW'(t_s3);
        ts3      = (ts <<< 1) + ts;
        h00_next = (tc <<< 1) - ts3 + H_ONE;
        h01_next = ts3 - (tc <<< 1);
        h10_next = tc - (ts <<< 1) + tv;
        h11_next = tc - ts;
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            tsq_reg <= tsq_prod[2*F:F];
        end
        if (en[3])
        begin
            tcub_reg   <= tcub_prod[2*F:F];
            tsq_s3_reg <= tsq_reg;
        end
        if (en[4])
        begin
            h00_reg <= h00_next;
            h01_reg <= h01_next;
            h10_reg <= h10_next;
            h11_reg <= h11_next;
        end
    end

    assign h00 = h00_reg;
    assign h01 = h01_reg;
    assign h10 = h10_reg;
    assign h11 = h11_reg;

endmodule

@@ design/cpe_hermite_lane.sv @@
// ----------------------------------------------------------------------------
// cpe_hermite_lane
// One coordinate of the Hermite spline: weighted products, a two-level
// adder tree, and the final floor shift by the parameter fraction bits.
// ----------------------------------------------------------------------------
module cpe_hermite_lane
    import cpe_pkg::*;
#(
    parameter int COORD_WIDTH     = 32,
    parameter int PARAM_FRAC_BITS = 16
)
(
    input  logic                              clk,
    input  logic [NUM_STAGES:1]               en,
    input  logic signed [COORD_WIDTH-1:0]     p0,
    input  logic signed [COORD_WIDTH-1:0]     p1,
    input  logic signed [COORD_WIDTH-1:0]     p2,
    input  logic signed [COORD_WIDTH-1:0]     p3,
    input  logic signed [PARAM_FRAC_BITS+3:0] h00,
    input  logic signed [PARAM_FRAC_BITS+3:0] h01,
    input  logic signed [PARAM_FRAC_BITS+3:0] h10,
    input  logic signed [PARAM_FRAC_BITS+3:0] h11,
    output logic signed [COORD_WIDTH+5:0]     sum
);

    localparam int CW  = COORD_WIDTH;
    localparam int F   = PARAM_FRAC_BITS;
    localparam int HW  = F + 4;
    localparam int PRW = CW + HW;
    localparam int TW  = PRW + 2;
    localparam int SW  = CW + 6;

    logic signed [CW-1:0]  pa_reg [4];
    logic signed [CW-1:0]  pb_reg [4];
    logic signed [CW-1:0]  pc_reg [4];
    logic signed [CW-1:0]  pd_reg [4];
    logic signed [HW-1:0]  w      [4];
    logic signed [PRW-1:0] prod_reg [4];
    logic signed [PRW:0]   pair0_reg, pair1_reg;
    logic signed [TW-1:0]  total_next;
    logic signed [SW-1:0]  sum_reg;

    assign w[0] = h00;
    assign w[1] = h01;
    assign w[2] = h10;
    assign w[3] = h11;

    // exact sum first, one arithmetic shift at the end
    always_comb
    begin
        total_next = (TW'(pair0_reg) + TW'(pair1_reg)) >>> F;
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            pa_reg[0] <= p0;
            pa_reg[1] <= p1;
            pa_reg[2] <= p2;
            pa_reg[3] <= p3;
        end
        for (int k = 0; k < 4; k++)
        begin
            if (en[2])
            begin
                pb_reg[k] <= pa_reg[k];
            end
            if (en[3])
            begin
                pc_reg[k] <= pb_reg[k];
            end
            if (en[4])
            begin
                pd_reg[k] <= pc_reg[k];
            end
            if (en[5])
            begin
                prod_reg[k] <= PRW'(pd_reg[k]) * PRW'(w[k]);
            end
        end
        if (en[6])
        begin
            pair0_reg <= (PRW+1)'(prod_reg[0]) + (PRW+1)'(prod_reg[1]);
            pair1_reg <= (PRW+1)'(prod_reg[2]) + (PRW+1)'(prod_reg[3]);
        end
        if (en[7])
        begin
            sum_reg <= total_next[SW-1:0];
        end
    end

    assign sum = sum_reg;

endmodule

@@ design/curve_point_evaluator_core.sv @@
// ----------------------------------------------------------------------------
// curve_point_evaluator_core
// Evaluates one 2D point per request: lerp, quadratic or cubic Bezier by
// repeated lerp, or a cubic Hermite spline; the Hermite result saturates.
// ----------------------------------------------------------------------------
//
//  Channel   Modport   Transaction carries
//  -------   -------   -------------------------------------------------
//  cmd       sink      func, pt0_x..pt3_y (Q16.16), curve_param (Q1.16)
//  rsp       source    out_x, out_y (Q16.16), saturated
//
//  Fully pipelined: one transaction per cycle while rsp is ready (stages
//  1-7 of lanes, stage 8 the output register). The Hermite path runs
//  alongside in the same stages and sets the depth; the three lerp levels,
//  each a subtract stage and a multiply-add stage, end before its final sum.
//  rst_n clears only the per-stage valid bits; payload flops are not reset.
//  A stage holds while it is full and the stage after it holds; an empty
//  stage always loads, so bubbles collapse under a stalled rsp.
// ----------------------------------------------------------------------------
module curve_point_evaluator_core
    import cpe_pkg::*;
#(
    parameter int COORD_WIDTH     = 32,
    parameter int PARAM_FRAC_BITS = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    cpe_in_if.sink     cmd,
    cpe_out_if.source  rsp
);

    localparam int CW = COORD_WIDTH;
    localparam int F  = PARAM_FRAC_BITS;
    localparam int HW = F + 4;
    localparam int SW = CW + 6;
    localparam logic [F:0] T_ONE = (F+1)'(1) << F;
    localparam logic signed [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};

    // ---- stage handshake -------------------------------------------------
    logic [NUM_STAGES:1] valid_reg;
    logic [NUM_STAGES:1] valid_next;
    logic [NUM_STAGES:1] en;

    always_comb
    begin
        // advance a stage when it is empty or its successor advances
        en[NUM_STAGES] = !valid_reg[NUM_STAGES] || rsp.ready;
        for (int k = NUM_STAGES - 1; k >= 1; k--)
        begin
            en[k] = !valid_reg[k] || en[k+1];
        end
        valid_next[1] = en[1] ? cmd.valid : valid_reg[1];
        for (int k = 2; k <= NUM_STAGES; k++)
        begin
            valid_next[k] = en[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign cmd.ready = en[1];

    // ---- parameter and mode side pipeline ---------------------------------
    logic [F:0] t_next;
    logic [F:0] t_s1_reg, t_s2_reg, t_s3_reg, t_s4_reg, t_s5_reg;
    func_t      func_reg [1:NUM_STAGES-1];

    // clamp t to one so Bezier results stay inside the control hull
    assign t_next = (cmd.curve_param > T_ONE) ? T_ONE : cmd.curve_param;

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            t_s1_reg    <= t_next;
            func_reg[1] <= cmd.func;
        end
        if (en[2])
        begin
            t_s2_reg <= t_s1_reg;
        end
        if (en[3])
        begin
            t_s3_reg <= t_s2_reg;
        end
        if (en[4])
        begin
            t_s4_reg <= t_s3_reg;
        end
        if (en[5])
        begin
            t_s5_reg <= t_s4_reg;
        end
        for (int k = 2; k <= NUM_STAGES - 1; k++)
        begin
            if (en[k])
            begin
                func_reg[k] <= func_reg[k-1];
            end
        end
    end

    // ---- Bezier lanes ----------------------------------------------------
    logic signed [CW-1:0] lin_x, quad_x, cubic_x;
    logic signed [CW-1:0] lin_y, quad_y, cubic_y;

    cpe_bezier_lane #(
        .COORD_WIDTH     (CW),
        .PARAM_FRAC_BITS (F)
    ) u_bezier_x (
        .clk   (clk),
        .en    (en),
        .p0    (cmd.pt0_x),
        .p1    (cmd.pt1_x),
        .p2    (cmd.pt2_x),
        .p3    (cmd.pt3_x),
        .t_s1  (t_s1_reg),
        .t_s3  (t_s3_reg),
        .t_s5  (t_s5_reg),
        .lin   (lin_x),
        .quad  (quad_x),
        .cubic (cubic_x)
    );

    cpe_bezier_lane #(
        .COORD_WIDTH     (CW),
        .PARAM_FRAC_BITS (F)
    ) u_bezier_y (
        .clk   (clk),
        .en    (en),
        .p0    (cmd.pt0_y),
        .p1    (cmd.pt1_y),
        .p2    (cmd.pt2_y),
        .p3    (cmd.pt3_y),
        .t_s1  (t_s1_reg),
        .t_s3  (t_s3_reg),
        .t_s5  (t_s5_reg),
        .lin   (lin_y),
        .quad  (quad_y),
        .cubic (cubic_y)
    );

    // ---- Hermite weights and lanes ----------------------------------------
    logic signed [HW-1:0] h00, h01, h10, h11;
    logic signed [SW-1:0] herm_x, herm_y;

    cpe_hermite_weights #(
        .PARAM_FRAC_BITS (F)
    ) u_weights (
        .clk  (clk),
        .en   (en),
        .t_s1 (t_s1_reg),
        .t_s2 (t_s2_reg),
        .t_s3 (t_s3_reg),
        .h00  (h00),
        .h01  (h01),
        .h10  (h10),
        .h11  (h11)
    );

    cpe_hermite_lane #(
        .COORD_WIDTH     (CW),
        .PARAM_FRAC_BITS (F)
    ) u_hermite_x (
        .clk (clk),
        .en  (en),
        .p0  (cmd.pt0_x),
        .p1  (cmd.pt1_x),
        .p2  (cmd.pt2_x),
        .p3  (cmd.pt3_x),
        .h00 (h00),
        .h01 (h01),
        .h10 (h10),
        .h11 (h11),
        .sum (herm_x)
    );

    cpe_hermite_lane #(
        .COORD_WIDTH     (CW),
        .PARAM_FRAC_BITS (F)
    ) u_hermite_y (
        .clk (clk),
        .en  (en),
        .p0  (cmd.pt0_y),
        .p1  (cmd.pt1_y),
        .p2  (cmd.pt2_y),
        .p3  (cmd.pt3_y),
        .h00 (h00),
        .h01 (h01),
        .h10 (h10),
        .h11 (h11),
        .sum (herm_y)
    );

    // ---- saturate, select and output register -----------------------------
    // The value fits when every bit from the coordinate's sign bit upward
    // matches; otherwise clamp toward the sign of the wide sum.
    function automatic logic in_range(input logic signed [SW-1:0] v);
        return (&v[SW-1:CW-1]) || !(|v[SW-1:CW-1]);
    endfunction

    function automatic logic signed [CW-1:0] clamp(input logic signed [SW-1:0] v);
        if (in_range(v))
        begin
            return v[CW-1:0];
        end
        return v[SW-1] ? COORD_MIN : COORD_MAX;
    endfunction

    logic signed [CW-1:0] x_next, y_next;
    logic                 sat_next;
    logic signed [CW-1:0] out_x_reg, out_y_reg;
    logic                 sat_reg;

    always_comb
    begin
        sat_next = 1'b0;
        unique case (func_reg[NUM_STAGES-1])
            FUNC_LINEAR:
            begin
                x_next = lin_x;
                y_next = lin_y;
            end
            FUNC_QUAD:
            begin
                x_next = quad_x;
                y_next = quad_y;
            end
            FUNC_CUBIC:
            begin
                x_next = cubic_x;
                y_next = cubic_y;
            end
            FUNC_HERMITE:
            begin
                x_next   = clamp(herm_x);
                y_next   = clamp(herm_y);
                sat_next = !in_range(herm_x) || !in_range(herm_y);
            end
            default:
            begin
                x_next = lin_x;
                y_next = lin_y;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en[NUM_STAGES])
        begin
            out_x_reg <= x_next;
            out_y_reg <= y_next;
            sat_reg   <= sat_next;
        end
    end

    assign rsp.valid     = valid_reg[NUM_STAGES];
    assign rsp.out_x     = out_x_reg;
    assign rsp.out_y     = out_y_reg;
    assign rsp.saturated = sat_reg;

endmodule
